FILE: sv/vdf_pkg.sv
// ----------------------------------------------------------------------------
// vdf_pkg: shared constants and types for the dimension fit block
// Register indexes, reset limits, sequencer states and the control and
// status groups between the top level and the engine.
// ----------------------------------------------------------------------------
package vdf_pkg;

	localparam int DIM_BITS_DEF  = 13;
	localparam int TINY_SIDE     = 10;
	localparam int RESET_LIMIT_W = 1920;
	localparam int RESET_LIMIT_H = 1440;

	localparam int          CFG_IDX_BITS = 1;
	localparam logic [0:0]  REG_LIMIT_W  = 1'b0;
	localparam logic [0:0]  REG_LIMIT_H  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIVX,
		ST_DIVY,
		ST_MUL,
		ST_DIVS,
		ST_DONE
	} vdf_state_t;

	typedef struct packed {
		logic start;
		logic take;
		logic land;
		logic port;
	} vdf_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} vdf_sts_t;

endpackage

FILE: sv/vdf_size_if.sv
// ----------------------------------------------------------------------------
// vdf_size_if: decoded frame size channel
// Valid/ready channel carrying one frame width and height per word.
// ----------------------------------------------------------------------------
interface vdf_size_if #(
	parameter int DIM_BITS = vdf_pkg::DIM_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic [DIM_BITS-1:0] in_width;
	logic [DIM_BITS-1:0] in_height;

	modport source (output valid, output in_width, output in_height, input ready);
	modport sink (input valid, input in_width, input in_height, output ready);
endinterface

FILE: sv/vdf_fit_if.sv
// ----------------------------------------------------------------------------
// vdf_fit_if: fitted size and aspect ratio channel
// Valid/ready channel carrying output size and reduced ratio per word.
// ----------------------------------------------------------------------------
interface vdf_fit_if #(
	parameter int DIM_BITS = vdf_pkg::DIM_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic [DIM_BITS-1:0] out_width;
	logic [DIM_BITS-1:0] out_height;
	logic [DIM_BITS-1:0] ratio_x;
	logic [DIM_BITS-1:0] ratio_y;

	modport source (output valid, output out_width, output out_height,
		output ratio_x, output ratio_y, input ready);
	modport sink (input valid, input out_width, input out_height,
		input ratio_x, input ratio_y, output ready);
endinterface

FILE: sv/vdf_engine.sv
// ----------------------------------------------------------------------------
// vdf_engine: sequenced GCD, ratio and scaling engine
// One subtractor serves a binary GCD loop and a restoring bit-serial
// divider; a single multiply forms the scaling product.
// ----------------------------------------------------------------------------
module vdf_engine #(
	parameter int DIM_BITS = vdf_pkg::DIM_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vdf_pkg::vdf_ctl_t   ctl,
	output vdf_pkg::vdf_sts_t   sts,
	input  logic [DIM_BITS-1:0] side_w,
	input  logic [DIM_BITS-1:0] side_h,
	input  logic [DIM_BITS-1:0] limit_w,
	input  logic [DIM_BITS-1:0] limit_h,
	output logic [DIM_BITS-1:0] res_w,
	output logic [DIM_BITS-1:0] res_h,
	output logic [DIM_BITS-1:0] res_rx,
	output logic [DIM_BITS-1:0] res_ry
);
	localparam int QW = 2 * DIM_BITS;
	localparam int KW = $clog2(DIM_BITS + 1);
	localparam int CW = $clog2(QW + 1);

	vdf_pkg::vdf_state_t state_q, state_d;

	logic [DIM_BITS-1:0] a_q, b_q, w_q, h_q, g_q, rx_q, ry_q, rem_q;
	logic [QW-1:0]       quo_q;
	logic [KW-1:0]       k_q;
	logic [CW-1:0]       cnt_q;
	logic                land_q, port_q;

	logic [DIM_BITS:0]   op_a, op_b;
	logic [DIM_BITS+1:0] diff;
	logic                borrow;
	logic [DIM_BITS-1:0] den;
	logic                gcd_end;
	logic [DIM_BITS-1:0] sat, fit_w, fit_h;

	assign den     = (state_q == vdf_pkg::ST_DIVS) ? (land_q ? rx_q : ry_q) : g_q;
	assign gcd_end = (a_q == '0) || (b_q == '0);

	always_comb begin
		if (state_q == vdf_pkg::ST_GCD) begin
			op_a = {1'b0, a_q};
			op_b = {1'b0, b_q};
		end else begin
			op_a = {rem_q, quo_q[QW-1]};
			op_b = {1'b0, den};
		end
	end

	assign diff   = {1'b0, op_a} - {1'b0, op_b};
	assign borrow = diff[DIM_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vdf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			vdf_pkg::ST_IDLE: begin
				if (ctl.start) state_d = vdf_pkg::ST_GCD;
			end
			vdf_pkg::ST_GCD: begin
				if (gcd_end) state_d = vdf_pkg::ST_DIVX;
			end
			vdf_pkg::ST_DIVX: begin
				if (cnt_q == '0) state_d = vdf_pkg::ST_DIVY;
			end
			vdf_pkg::ST_DIVY: begin
				if (cnt_q == '0)
					state_d = (land_q || port_q) ? vdf_pkg::ST_MUL : vdf_pkg::ST_DONE;
			end
			vdf_pkg::ST_MUL: begin
				state_d = vdf_pkg::ST_DIVS;
			end
			vdf_pkg::ST_DIVS: begin
				if (cnt_q == '0) state_d = vdf_pkg::ST_DONE;
			end
			vdf_pkg::ST_DONE: begin
				if (ctl.take) state_d = vdf_pkg::ST_IDLE;
			end
			default: state_d = vdf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			land_q <= 1'b0;
			port_q <= 1'b0;
		end else begin
			case (state_q)
				vdf_pkg::ST_IDLE: begin
					if (ctl.start) begin
						land_q <= ctl.land;
						port_q <= ctl.port;
					end
				end
				vdf_pkg::ST_GCD: begin
					if (gcd_end) cnt_q <= CW'(DIM_BITS);
				end
				vdf_pkg::ST_DIVX, vdf_pkg::ST_DIVY, vdf_pkg::ST_DIVS: begin
					if (cnt_q == '0) begin
						if (state_q == vdf_pkg::ST_DIVX) cnt_q <= CW'(DIM_BITS);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				vdf_pkg::ST_MUL: begin
					cnt_q <= CW'(QW);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			vdf_pkg::ST_IDLE: begin
				if (ctl.start) begin
					a_q <= side_w;
					b_q <= side_h;
					w_q <= side_w;
					h_q <= side_h;
					k_q <= '0;
				end
			end
			vdf_pkg::ST_GCD: begin
				if (gcd_end) begin
					g_q   <= (a_q | b_q) << k_q;
					quo_q <= {w_q, {DIM_BITS{1'b0}}};
					rem_q <= '0;
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (borrow) begin
					a_q <= b_q;
					b_q <= a_q;
				end else begin
					a_q <= diff[DIM_BITS-1:0];
				end
			end
			vdf_pkg::ST_DIVX, vdf_pkg::ST_DIVY, vdf_pkg::ST_DIVS: begin
				if (cnt_q == '0) begin
					if (state_q == vdf_pkg::ST_DIVX) begin
						rx_q  <= (g_q == '0) ? '0 : quo_q[DIM_BITS-1:0];
						quo_q <= {h_q, {DIM_BITS{1'b0}}};
						rem_q <= '0;
					end else if (state_q == vdf_pkg::ST_DIVY) begin
						ry_q <= (g_q == '0) ? '0 : quo_q[DIM_BITS-1:0];
					end
				end else begin
					rem_q <= borrow ? op_a[DIM_BITS-1:0] : diff[DIM_BITS-1:0];
					quo_q <= {quo_q[QW-2:0], ~borrow};
				end
			end
			vdf_pkg::ST_MUL: begin
				quo_q <= land_q ? (QW'(limit_w) * QW'(ry_q)) : (QW'(limit_h) * QW'(rx_q));
				rem_q <= '0;
			end
			default: ;
		endcase
	end

	assign sat   = (quo_q[QW-1:DIM_BITS] != '0) ? '1 : quo_q[DIM_BITS-1:0];
	assign fit_w = land_q ? limit_w : (port_q ? sat : w_q);
	assign fit_h = land_q ? sat : (port_q ? limit_h : h_q);

	assign res_w  = {fit_w[DIM_BITS-1:1], 1'b0};
	assign res_h  = {fit_h[DIM_BITS-1:1], 1'b0};
	assign res_rx = rx_q;
	assign res_ry = ry_q;

	assign sts.idle = (state_q == vdf_pkg::ST_IDLE);
	assign sts.done = (state_q == vdf_pkg::ST_DONE);

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> state_q == vdf_pkg::ST_IDLE)
		else $error("start while busy");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QW))
		else $error("bit counter out of range");

	a_divx_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vdf_pkg::ST_GCD && gcd_end) |=> cnt_q == CW'(DIM_BITS))
		else $error("divider not loaded after gcd");

	a_one_fit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != vdf_pkg::ST_IDLE) |-> !(land_q && port_q))
		else $error("both fit directions set");

	a_take_done: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.take && state_q == vdf_pkg::ST_DONE) |=> state_q == vdf_pkg::ST_IDLE)
		else $error("result taken but engine held");

endmodule

FILE: sv/video_dimension_fit.sv
// ----------------------------------------------------------------------------
// video_dimension_fit: output size and aspect ratio for a decoded frame
//
//   port      dir   handshake      payload
//   size      sink  valid/ready    in_width, in_height
//   fit       src   valid/ready    out_width, out_height, ratio_x, ratio_y
//   cfg_*     sink  cfg_we         cfg_index, cfg_wdata
//
// The binary GCD loop and the bit-serial divider share one subtractor.
// One word is in work at a time; size.ready is high only while the engine
// idles, and a finished result waits in the output register meanwhile.
// Reset sets the limits to 1920 by 1440 and empties the output register.
// ----------------------------------------------------------------------------
module video_dimension_fit #(
	parameter int DIM_BITS = vdf_pkg::DIM_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	vdf_size_if.sink                          size,
	vdf_fit_if.source                         fit,
	input  logic                              cfg_we,
	input  logic [vdf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [DIM_BITS-1:0]               cfg_wdata
);
	localparam logic [DIM_BITS-1:0] TINY = DIM_BITS'(vdf_pkg::TINY_SIDE);

	logic [DIM_BITS-1:0] limit_w_q, limit_h_q;
	logic [DIM_BITS-1:0] side_w, side_h;
	logic [DIM_BITS-1:0] res_w, res_h, res_rx, res_ry;
	logic [DIM_BITS-1:0] out_w_q, out_h_q, out_rx_q, out_ry_q;
	logic                out_valid_q;
	logic                tiny;

	vdf_pkg::vdf_ctl_t ctl;
	vdf_pkg::vdf_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_w_q <= DIM_BITS'(vdf_pkg::RESET_LIMIT_W);
			limit_h_q <= DIM_BITS'(vdf_pkg::RESET_LIMIT_H);
		end else if (cfg_we) begin
			case (cfg_index)
				vdf_pkg::REG_LIMIT_W: limit_w_q <= cfg_wdata;
				vdf_pkg::REG_LIMIT_H: limit_h_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign tiny   = (size.in_width <= TINY) || (size.in_height <= TINY);
	assign side_w = tiny ? limit_w_q : size.in_width;
	assign side_h = tiny ? limit_h_q : size.in_height;

	assign size.ready = sts.idle;

	assign ctl.start = size.valid && sts.idle;
	assign ctl.take  = sts.done && (!out_valid_q || fit.ready);
	assign ctl.land  = (size.in_width >= size.in_height) && (size.in_width > limit_w_q);
	assign ctl.port  = (size.in_width < size.in_height) && (size.in_height > limit_h_q);

	vdf_engine #(
		.DIM_BITS(DIM_BITS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.sts     (sts),
		.side_w  (side_w),
		.side_h  (side_h),
		.limit_w (limit_w_q),
		.limit_h (limit_h_q),
		.res_w   (res_w),
		.res_h   (res_h),
		.res_rx  (res_rx),
		.res_ry  (res_ry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.take) begin
			out_valid_q <= 1'b1;
		end else if (fit.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			out_w_q  <= res_w;
			out_h_q  <= res_h;
			out_rx_q <= res_rx;
			out_ry_q <= res_ry;
		end
	end

	assign fit.valid      = out_valid_q;
	assign fit.out_width  = out_w_q;
	assign fit.out_height = out_h_q;
	assign fit.ratio_x    = out_rx_q;
	assign fit.ratio_y    = out_ry_q;

endmodule
